// ----- hw/rtl/prts_pkg.sv -----
// Shared types and codes for the priority round robin task scheduler.
// Used by prts_ctrl, prts_datapath and the top level; depends on nothing.
package prts_pkg;

    localparam logic [3:0] ACT_CREATE    = 4'd0;
    localparam logic [3:0] ACT_SET_PRIO  = 4'd1;
    localparam logic [3:0] ACT_RESTORE   = 4'd2;
    localparam logic [3:0] ACT_SET_SLICE = 4'd3;
    localparam logic [3:0] ACT_MODE      = 4'd4;
    localparam logic [3:0] ACT_WAKE      = 4'd5;
    localparam logic [3:0] ACT_BLOCK     = 4'd6;
    localparam logic [3:0] ACT_SCHEDULE  = 4'd7;
    localparam logic [3:0] ACT_TICK      = 4'd8;
    localparam logic [3:0] ACT_QUERY     = 4'd9;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_BAD_PRIO  = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;
    localparam logic [1:0] STS_WRONG     = 2'd3;

    localparam logic [1:0] SLOT_FREE     = 2'd0;
    localparam logic [1:0] SLOT_READY    = 2'd1;
    localparam logic [1:0] SLOT_RUN      = 2'd2;
    localparam logic [1:0] SLOT_WAIT     = 2'd3;

    localparam logic [4:0] FLOOR_RESET   = 5'd8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic eval;
        logic deq;
        logic enq;
        logic disp;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

// ----- hw/rtl/prts_ctrl.sv -----
// Sequencing state machine of the task scheduler.
// Depends on prts_pkg for the command and status structs.
module prts_ctrl
    import prts_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t sts,
    output dp_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EVAL = 6'b000010,
        ST_DEQ  = 6'b000100,
        ST_ENQ  = 6'b001000,
        ST_DISP = 6'b010000,
        ST_DONE = 6'b100000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.latch = s_valid;
                if (s_valid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = ST_DEQ;
            end
            ST_DEQ: begin
                cmd.deq    = 1'b1;
                state_next = ST_ENQ;
            end
            ST_ENQ: begin
                cmd.enq    = 1'b1;
                state_next = ST_DISP;
            end
            ST_DISP: begin
                cmd.disp   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/prts_datapath.sv -----
// Task table, ready lists and result register of the task scheduler.
// Depends on prts_pkg; driven by prts_ctrl through dp_cmd_t.
module prts_datapath
    import prts_pkg::*;
#(
    parameter int TASK_SLOTS  = 16,
    parameter int PRIO_LEVELS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic [3:0]  in_action,
    input  logic [3:0]  in_task_id,
    input  logic        in_use_current,
    input  logic [4:0]  in_new_priority,
    input  logic [15:0] in_slice_value,
    input  logic        in_non_preemptive,
    input  logic        in_force_req,
    input  dp_cmd_t     cmd,
    output dp_status_t  sts,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [3:0]  m_running_task,
    output logic        m_running_valid,
    output logic        m_switched,
    output logic [3:0]  m_created_task,
    output logic [4:0]  m_read_priority,
    output logic [15:0] m_read_slice_left,
    output logic        m_read_non_preemptive,
    output logic [4:0]  m_ready_total
);

    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int PW = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;
    localparam int CW = $clog2(TASK_SLOTS + 1);

    // Latched transaction.
    logic [3:0]  act_reg;
    logic [3:0]  tid_reg;
    logic        usecur_reg;
    logic [4:0]  prio_reg;
    logic [15:0] slice_reg;
    logic        np_reg;
    logic        force_reg;

    // Task table.
    logic [1:0]  slot_state_reg [TASK_SLOTS];
    logic [PW-1:0] base_prio_reg [TASK_SLOTS];
    logic [PW-1:0] dyn_prio_reg  [TASK_SLOTS];
    logic [15:0] reload_reg [TASK_SLOTS];
    logic [15:0] left_reg   [TASK_SLOTS];
    logic        keeps_reg  [TASK_SLOTS];
    logic [SW-1:0] next_link_reg [TASK_SLOTS];
    logic [SW-1:0] prev_link_reg [TASK_SLOTS];
    logic [SW-1:0] head_reg [PRIO_LEVELS];
    logic [PRIO_LEVELS-1:0] nonempty_reg;
    logic [SW-1:0] cur_reg;
    logic        cur_valid_reg;
    logic [CW-1:0] cnt_reg;
    logic [4:0]  floor_reg;

    // Plan for the list steps.
    logic        deq_reg, enq_reg, disp_reg;
    logic [SW-1:0] deq_t_reg, enq_t_reg, disp_t_reg;
    logic [PW-1:0] enq_p_reg;

    // Result fields held until the final step.
    logic [1:0]  res_status_reg;
    logic        res_switched_reg;
    logic [SW-1:0] res_created_reg;
    logic [PW-1:0] res_rprio_reg;
    logic [15:0] res_rslice_reg;
    logic        res_rnp_reg;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_status_reg;
    logic [3:0]  out_run_reg;
    logic        out_run_valid_reg;
    logic        out_switched_reg;
    logic [3:0]  out_created_reg;
    logic [4:0]  out_rprio_reg;
    logic [15:0] out_rslice_reg;
    logic        out_rnp_reg;
    logic [4:0]  out_total_reg;

    // Addressing.
    logic [SW-1:0] t_idx;
    logic        addr_ok, prio_ok;
    logic [PW-1:0] prio_idx;

    always_comb begin
        t_idx    = usecur_reg ? cur_reg : SW'(tid_reg);
        addr_ok  = (usecur_reg ? cur_valid_reg : (32'(tid_reg) < TASK_SLOTS))
                   && (slot_state_reg[t_idx] != SLOT_FREE);
        prio_ok  = 32'(prio_reg) < PRIO_LEVELS;
        prio_idx = PW'(prio_reg);
    end

    // Lowest free slot and most urgent nonempty level.
    logic        free_found, lvl_found;
    logic [SW-1:0] free_idx;
    logic [PW-1:0] lvl_idx;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
            if (slot_state_reg[i] == SLOT_FREE) begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
        lvl_found = 1'b0;
        lvl_idx   = '0;
        for (int i = PRIO_LEVELS - 1; i >= 0; i--) begin
            if (nonempty_reg[i]) begin
                lvl_found = 1'b1;
                lvl_idx   = PW'(i);
            end
        end
    end

    // Decision for the latched transaction.
    logic [SW-1:0] best;
    logic        ev_deq, ev_enq, ev_disp, ev_sw;
    logic [SW-1:0] ev_deq_t, ev_enq_t;
    logic [PW-1:0] ev_enq_p, ev_new_p, ev_rprio;
    logic [1:0]  ev_status;
    logic [SW-1:0] ev_created;
    logic [15:0] ev_rslice;
    logic        ev_rnp;
    logic        do_create, do_dyn, do_slice, do_keeps, do_block, do_reload, do_dec;
    logic        change;
    logic        more_urgent, same_level;

    always_comb begin
        best       = head_reg[lvl_idx];
        ev_deq     = 1'b0;
        ev_enq     = 1'b0;
        ev_disp    = 1'b0;
        ev_sw      = 1'b0;
        ev_deq_t   = t_idx;
        ev_enq_t   = t_idx;
        ev_enq_p   = dyn_prio_reg[t_idx];
        ev_new_p   = prio_idx;
        ev_status  = STS_OK;
        ev_created = '0;
        ev_rprio   = '0;
        ev_rslice  = '0;
        ev_rnp     = 1'b0;
        do_create  = 1'b0;
        do_dyn     = 1'b0;
        do_slice   = 1'b0;
        do_keeps   = 1'b0;
        do_block   = 1'b0;
        do_reload  = 1'b0;
        do_dec     = 1'b0;
        change     = 1'b0;
        more_urgent = dyn_prio_reg[best] < dyn_prio_reg[cur_reg];
        same_level  = dyn_prio_reg[best] == dyn_prio_reg[cur_reg];
        unique case (act_reg)
            ACT_CREATE: begin
                if (!prio_ok) begin
                    ev_status = STS_BAD_PRIO;
                end else if (!free_found) begin
                    ev_status = STS_FULL;
                end else begin
                    do_create  = 1'b1;
                    ev_enq     = 1'b1;
                    ev_enq_t   = free_idx;
                    ev_enq_p   = prio_idx;
                    ev_created = free_idx;
                end
            end
            ACT_SET_PRIO: begin
                if (prio_reg < floor_reg || !prio_ok) begin
                    ev_status = STS_BAD_PRIO;
                end else if (!addr_ok) begin
                    ev_status = STS_WRONG;
                end else begin
                    change = 1'b1;
                end
            end
            ACT_RESTORE: begin
                ev_new_p = base_prio_reg[t_idx];
                if (!addr_ok) begin
                    ev_status = STS_WRONG;
                end else begin
                    change = 1'b1;
                end
            end
            ACT_SET_SLICE: begin
                if (!addr_ok) begin
                    ev_status = STS_WRONG;
                end else begin
                    do_slice = 1'b1;
                end
            end
            ACT_MODE: begin
                if (!addr_ok) begin
                    ev_status = STS_WRONG;
                end else begin
                    do_keeps = 1'b1;
                end
            end
            ACT_WAKE: begin
                if (!addr_ok || slot_state_reg[t_idx] != SLOT_WAIT) begin
                    ev_status = STS_WRONG;
                end else begin
                    ev_enq = 1'b1;
                end
            end
            ACT_BLOCK: begin
                if (!cur_valid_reg) begin
                    ev_status = STS_WRONG;
                end else begin
                    do_block = 1'b1;
                end
            end
            ACT_SCHEDULE: begin
                if (lvl_found) begin
                    if (!cur_valid_reg) begin
                        ev_disp = 1'b1;
                        ev_sw   = 1'b1;
                    end else if (force_reg || (!keeps_reg[cur_reg] && (more_urgent
                                 || (left_reg[cur_reg] == 16'd0 && same_level)))) begin
                        // The running task goes back to the tail of its level first.
                        do_reload = !force_reg && !more_urgent;
                        ev_enq    = 1'b1;
                        ev_enq_t  = cur_reg;
                        ev_enq_p  = dyn_prio_reg[cur_reg];
                        ev_disp   = 1'b1;
                        ev_sw     = 1'b1;
                    end
                end
            end
            ACT_TICK: begin
                do_dec = cur_valid_reg && (left_reg[cur_reg] != 16'd0);
            end
            ACT_QUERY: begin
                if (!addr_ok) begin
                    ev_status = STS_WRONG;
                end else begin
                    ev_rprio  = dyn_prio_reg[t_idx];
                    ev_rslice = left_reg[t_idx];
                    ev_rnp    = keeps_reg[t_idx];
                end
            end
            default: begin
            end
        endcase
        // A ready task changes level by unlinking and relinking.
        if (change) begin
            if (slot_state_reg[t_idx] == SLOT_READY) begin
                ev_deq   = 1'b1;
                ev_enq   = 1'b1;
                ev_enq_p = ev_new_p;
            end else begin
                do_dyn = 1'b1;
            end
        end
    end

    // Unlink and link steps.
    logic        u_act, e_act;
    logic [SW-1:0] u_t, u_n, u_pr, e_h, e_tail;
    logic [PW-1:0] u_p;
    logic        e_ne;

    always_comb begin
        u_act  = (cmd.deq && deq_reg) || (cmd.disp && disp_reg);
        u_t    = cmd.disp ? disp_t_reg : deq_t_reg;
        u_p    = dyn_prio_reg[u_t];
        u_n    = next_link_reg[u_t];
        u_pr   = prev_link_reg[u_t];
        e_act  = cmd.enq && enq_reg;
        e_ne   = nonempty_reg[enq_p_reg];
        e_h    = head_reg[enq_p_reg];
        e_tail = prev_link_reg[e_h];
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
                slot_state_reg[i] <= SLOT_FREE;
            end
            nonempty_reg  <= '0;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            floor_reg     <= FLOOR_RESET;
            deq_reg       <= 1'b0;
            enq_reg       <= 1'b0;
            disp_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                floor_reg <= cfg_wdata;
            end
            if (cmd.eval) begin
                deq_reg  <= ev_deq;
                enq_reg  <= ev_enq;
                disp_reg <= ev_disp;
                if (do_block) begin
                    slot_state_reg[cur_reg] <= SLOT_WAIT;
                    cur_valid_reg           <= 1'b0;
                end
            end
            if (u_act) begin
                if (u_n == u_t) begin
                    nonempty_reg[u_p] <= 1'b0;
                end
                if (cnt_reg != '0) begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
                if (cmd.disp) begin
                    slot_state_reg[u_t] <= SLOT_RUN;
                    cur_reg             <= u_t;
                    cur_valid_reg       <= 1'b1;
                end
            end
            if (e_act) begin
                nonempty_reg[enq_p_reg]   <= 1'b1;
                slot_state_reg[enq_t_reg] <= SLOT_READY;
                cnt_reg                   <= cnt_reg + 1'b1;
            end
        end
    end

    // Payload storage without reset.
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            act_reg    <= in_action;
            tid_reg    <= in_task_id;
            usecur_reg <= in_use_current;
            prio_reg   <= in_new_priority;
            slice_reg  <= in_slice_value;
            np_reg     <= in_non_preemptive;
            force_reg  <= in_force_req;
        end
        if (cmd.eval) begin
            deq_t_reg        <= ev_deq_t;
            enq_t_reg        <= ev_enq_t;
            enq_p_reg        <= ev_enq_p;
            disp_t_reg       <= best;
            res_status_reg   <= ev_status;
            res_switched_reg <= ev_sw;
            res_created_reg  <= ev_created;
            res_rprio_reg    <= ev_rprio;
            res_rslice_reg   <= ev_rslice;
            res_rnp_reg      <= ev_rnp;
            if (do_create) begin
                base_prio_reg[free_idx] <= prio_idx;
                reload_reg[free_idx]    <= slice_reg;
                left_reg[free_idx]      <= slice_reg;
                keeps_reg[free_idx]     <= 1'b0;
            end
            if (do_dyn) begin
                dyn_prio_reg[t_idx] <= ev_new_p;
            end
            if (do_slice) begin
                reload_reg[t_idx] <= slice_reg;
                left_reg[t_idx]   <= slice_reg;
            end
            if (do_keeps) begin
                keeps_reg[t_idx] <= np_reg;
            end
            if (do_reload) begin
                left_reg[cur_reg] <= reload_reg[cur_reg];
            end
            if (do_dec) begin
                left_reg[cur_reg] <= left_reg[cur_reg] - 16'd1;
            end
        end
        if (u_act && u_n != u_t) begin
            next_link_reg[u_pr] <= u_n;
            prev_link_reg[u_n]  <= u_pr;
            if (head_reg[u_p] == u_t) begin
                head_reg[u_p] <= u_n;
            end
        end
        if (e_act) begin
            dyn_prio_reg[enq_t_reg] <= enq_p_reg;
            if (e_ne) begin
                prev_link_reg[enq_t_reg] <= e_tail;
                next_link_reg[enq_t_reg] <= e_h;
                next_link_reg[e_tail]    <= enq_t_reg;
                prev_link_reg[e_h]       <= enq_t_reg;
            end else begin
                head_reg[enq_p_reg]      <= enq_t_reg;
                next_link_reg[enq_t_reg] <= enq_t_reg;
                prev_link_reg[enq_t_reg] <= enq_t_reg;
            end
        end
        if (cmd.finish) begin
            out_status_reg    <= res_status_reg;
            out_run_reg       <= cur_valid_reg ? 4'(cur_reg) : 4'd0;
            out_run_valid_reg <= cur_valid_reg;
            out_switched_reg  <= res_switched_reg;
            out_created_reg   <= 4'(res_created_reg);
            out_rprio_reg     <= 5'(res_rprio_reg);
            out_rslice_reg    <= res_rslice_reg;
            out_rnp_reg       <= res_rnp_reg;
            out_total_reg     <= 5'(cnt_reg);
        end
    end

    always_comb begin
        out_valid_next = cmd.finish ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
        sts.out_busy   = out_valid_reg && !m_ready;
    end

    assign m_valid               = out_valid_reg;
    assign m_status              = out_status_reg;
    assign m_running_task        = out_run_reg;
    assign m_running_valid       = out_run_valid_reg;
    assign m_switched            = out_switched_reg;
    assign m_created_task        = out_created_reg;
    assign m_read_priority       = out_rprio_reg;
    assign m_read_slice_left     = out_rslice_reg;
    assign m_read_non_preemptive = out_rnp_reg;
    assign m_ready_total         = out_total_reg;

endmodule

// ----- hw/rtl/priority_round_robin_task_scheduler.sv -----
// Top level of the priority round robin task scheduler.
// Instantiates prts_ctrl and prts_datapath; depends on prts_pkg.
//
//  channel  direction  handshake            contents
//  s_*      in         s_valid / s_ready    one scheduler request per transaction
//  m_*      out        m_valid / m_ready    one result per request
//  cfg_*    in         cfg_we (no wait)     kernel priority floor
//
// A request is latched at its accepting edge. The sequencer then decides, runs the
// unlink, link and dispatch steps on the ready lists, and loads the result register.
// The sequencer goes back to idle as the result is loaded, and a new request is
// accepted only in idle, so requests never overlap.
// Reset is synchronous and active low; it frees all slots and empties lists.
// A result waiting on m_ready holds the sequencer in its final step.
module priority_round_robin_task_scheduler
    import prts_pkg::*;
#(
    parameter int TASK_SLOTS  = 16,
    parameter int PRIO_LEVELS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_action,
    input  logic [3:0]  s_task_id,
    input  logic        s_use_current,
    input  logic [4:0]  s_new_priority,
    input  logic [15:0] s_slice_value,
    input  logic        s_non_preemptive,
    input  logic        s_force_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [3:0]  m_running_task,
    output logic        m_running_valid,
    output logic        m_switched,
    output logic [3:0]  m_created_task,
    output logic [4:0]  m_read_priority,
    output logic [15:0] m_read_slice_left,
    output logic        m_read_non_preemptive,
    output logic [4:0]  m_ready_total
);

    // The controller and datapath talk only through these two structs.
    dp_cmd_t    cmd;
    dp_status_t sts;

    prts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    prts_datapath #(
        .TASK_SLOTS  (TASK_SLOTS),
        .PRIO_LEVELS (PRIO_LEVELS)
    ) u_datapath (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_we                (cfg_we),
        .cfg_wdata             (cfg_wdata),
        .in_action             (s_action),
        .in_task_id            (s_task_id),
        .in_use_current        (s_use_current),
        .in_new_priority       (s_new_priority),
        .in_slice_value        (s_slice_value),
        .in_non_preemptive     (s_non_preemptive),
        .in_force_req          (s_force_req),
        .cmd                   (cmd),
        .sts                   (sts),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_status              (m_status),
        .m_running_task        (m_running_task),
        .m_running_valid       (m_running_valid),
        .m_switched            (m_switched),
        .m_created_task        (m_created_task),
        .m_read_priority       (m_read_priority),
        .m_read_slice_left     (m_read_slice_left),
        .m_read_non_preemptive (m_read_non_preemptive),
        .m_ready_total         (m_ready_total)
    );

endmodule

// ----- verif/priority_round_robin_task_scheduler_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the priority round robin task scheduler.
// Depends on prts_pkg and priority_round_robin_task_scheduler, which needs prts_ctrl and prts_datapath.
module priority_round_robin_task_scheduler_tb;
    import prts_pkg::*;

    localparam int SLOTS  = 16;
    localparam int LEVELS = 32;

    // One scheduler request as it travels on the s_ channel.
    typedef struct packed {
        logic [3:0]  action;
        logic [3:0]  tid;
        logic        usecur;
        logic [4:0]  prio;
        logic [15:0] slice;
        logic        np;
        logic        frc;
    } sched_req_t;

    // One scheduler result as it travels on the m_ channel.
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  run_task;
        logic        run_valid;
        logic        switched;
        logic [3:0]  created;
        logic [4:0]  rprio;
        logic [15:0] rslice;
        logic        rnp;
        logic [4:0]  ready_total;
    } sched_rsp_t;

    // A row of the directed table. Where known_rsp is set, the row carries a
    // result that is obvious from the state; otherwise the scheduler mirror
    // provides the expected result.
    typedef struct packed {
        sched_req_t req;
        logic       known_rsp;
        sched_rsp_t rsp;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [4:0]  cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [3:0]  s_action;
    logic [3:0]  s_task_id;
    logic        s_use_current;
    logic [4:0]  s_new_priority;
    logic [15:0] s_slice_value;
    logic        s_non_preemptive;
    logic        s_force_req;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [3:0]  m_running_task;
    logic        m_running_valid;
    logic        m_switched;
    logic [3:0]  m_created_task;
    logic [4:0]  m_read_priority;
    logic [15:0] m_read_slice_left;
    logic        m_read_non_preemptive;
    logic [4:0]  m_ready_total;

    priority_round_robin_task_scheduler u_top (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_we                (cfg_we),
        .cfg_wdata             (cfg_wdata),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_action              (s_action),
        .s_task_id             (s_task_id),
        .s_use_current         (s_use_current),
        .s_new_priority        (s_new_priority),
        .s_slice_value         (s_slice_value),
        .s_non_preemptive      (s_non_preemptive),
        .s_force_req           (s_force_req),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_status              (m_status),
        .m_running_task        (m_running_task),
        .m_running_valid       (m_running_valid),
        .m_switched            (m_switched),
        .m_created_task        (m_created_task),
        .m_read_priority       (m_read_priority),
        .m_read_slice_left     (m_read_slice_left),
        .m_read_non_preemptive (m_read_non_preemptive),
        .m_ready_total         (m_ready_total)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // The run can never legitimately take this long; stop with a failure.
    initial begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Scheduler mirror. It keeps its own copy of the task table, the ready
    // lists and the priority floor, and it is advanced once per accepted
    // transaction, in acceptance order.
    // ------------------------------------------------------------------
    logic [1:0]  m_slot_state  [SLOTS];
    logic [4:0]  m_base_prio   [SLOTS];
    logic [4:0]  m_dyn_prio    [SLOTS];
    logic [15:0] m_slice_rld   [SLOTS];
    logic [15:0] m_slice_cnt   [SLOTS];
    logic        m_keeps       [SLOTS];
    logic [3:0]  m_next        [SLOTS];
    logic [3:0]  m_prev        [SLOTS];
    logic [3:0]  m_head        [LEVELS];
    logic [LEVELS-1:0] m_nonempty;
    logic [3:0]  m_cur;
    logic        m_cur_valid;
    logic [4:0]  m_ready_cnt;
    logic [4:0]  m_floor;

    sched_rsp_t  pending_rsp[$];
    int          err_cnt;

    function automatic void mirror_reset();
        for (int i = 0; i < SLOTS; i++) m_slot_state[i] = SLOT_FREE;
        m_nonempty  = '0;
        m_cur       = '0;
        m_cur_valid = 1'b0;
        m_ready_cnt = '0;
        m_floor     = FLOOR_RESET;
    endfunction

    // Append a task at the tail of its level's circular list.
    function automatic void link_tail(logic [3:0] t);
        logic [4:0] p;
        logic [3:0] h;
        logic [3:0] tl;
        p = m_dyn_prio[t];
        if (m_nonempty[p]) begin
            h  = m_head[p];
            tl = m_prev[h];
            m_prev[t]  = tl;
            m_next[t]  = h;
            m_next[tl] = t;
            m_prev[h]  = t;
        end else begin
            m_head[p]     = t;
            m_next[t]     = t;
            m_prev[t]     = t;
            m_nonempty[p] = 1'b1;
        end
        m_slot_state[t] = SLOT_READY;
        m_ready_cnt++;
    endfunction

    function automatic void unlink(logic [3:0] t);
        logic [4:0] p;
        p = m_dyn_prio[t];
        if (m_next[t] == t) begin
            m_nonempty[p] = 1'b0;
        end else begin
            m_next[m_prev[t]] = m_next[t];
            m_prev[m_next[t]] = m_prev[t];
            if (m_head[p] == t) m_head[p] = m_next[t];
        end
        if (m_ready_cnt > 0) m_ready_cnt--;
    endfunction

    function automatic void run_task(logic [3:0] t);
        unlink(t);
        m_slot_state[t] = SLOT_RUN;
        m_cur           = t;
        m_cur_valid     = 1'b1;
    endfunction

    function automatic void move_level(logic [3:0] t, logic [4:0] p);
        if (m_slot_state[t] == SLOT_READY) begin
            unlink(t);
            m_dyn_prio[t] = p;
            link_tail(t);
        end else begin
            m_dyn_prio[t] = p;
        end
    endfunction

    // Preemption and round robin decision; returns 1 when a switch happened.
    function automatic logic pick_and_switch(logic frc);
        logic [3:0] best;
        logic       found;
        found = 1'b0;
        best  = '0;
        for (int p = 0; p < LEVELS; p++) begin
            if (!found && m_nonempty[p]) begin
                best  = m_head[p];
                found = 1'b1;
            end
        end
        if (!found) return 1'b0;
        if (!m_cur_valid) begin
            run_task(best);
            return 1'b1;
        end
        if (!frc) begin
            if (m_keeps[m_cur]) return 1'b0;
            if (m_dyn_prio[best] >= m_dyn_prio[m_cur]) begin
                // Equal level only rotates once the slice is spent.
                if (m_slice_cnt[m_cur] != 16'd0) return 1'b0;
                if (m_dyn_prio[best] != m_dyn_prio[m_cur]) return 1'b0;
                m_slice_cnt[m_cur] = m_slice_rld[m_cur];
            end
        end
        link_tail(m_cur);
        run_task(best);
        return 1'b1;
    endfunction

    function automatic sched_rsp_t schedule_outcome(sched_req_t r);
        sched_rsp_t o;
        logic [3:0] t;
        logic       hit;
        logic       s;
        o   = '0;
        t   = r.usecur ? m_cur : r.tid;
        hit = (r.usecur ? m_cur_valid : 1'b1) && (m_slot_state[t] != SLOT_FREE);
        case (r.action)
            ACT_CREATE: begin
                s = 1'b0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!s && m_slot_state[i] == SLOT_FREE) begin
                        s = 1'b1;
                        t = i[3:0];
                    end
                end
                if (!s) begin
                    o.status = STS_FULL;
                end else begin
                    m_base_prio[t] = r.prio;
                    m_dyn_prio[t]  = r.prio;
                    m_slice_rld[t] = r.slice;
                    m_slice_cnt[t] = r.slice;
                    m_keeps[t]     = 1'b0;
                    link_tail(t);
                    o.created = t;
                end
            end
            ACT_SET_PRIO: begin
                if (r.prio < m_floor) o.status = STS_BAD_PRIO;
                else if (!hit)        o.status = STS_WRONG;
                else                  move_level(t, r.prio);
            end
            ACT_RESTORE: begin
                if (!hit) o.status = STS_WRONG;
                else      move_level(t, m_base_prio[t]);
            end
            ACT_SET_SLICE: begin
                if (!hit) begin
                    o.status = STS_WRONG;
                end else begin
                    m_slice_rld[t] = r.slice;
                    m_slice_cnt[t] = r.slice;
                end
            end
            ACT_MODE: begin
                if (!hit) o.status = STS_WRONG;
                else      m_keeps[t] = r.np;
            end
            ACT_WAKE: begin
                if (!hit || m_slot_state[t] != SLOT_WAIT) o.status = STS_WRONG;
                else                                      link_tail(t);
            end
            ACT_BLOCK: begin
                if (!m_cur_valid) begin
                    o.status = STS_WRONG;
                end else begin
                    m_slot_state[m_cur] = SLOT_WAIT;
                    m_cur_valid         = 1'b0;
                end
            end
            ACT_SCHEDULE: o.switched = pick_and_switch(r.frc);
            ACT_TICK: begin
                if (m_cur_valid && m_slice_cnt[m_cur] != 16'd0) m_slice_cnt[m_cur]--;
            end
            ACT_QUERY: begin
                if (!hit) begin
                    o.status = STS_WRONG;
                end else begin
                    o.rprio  = m_dyn_prio[t];
                    o.rslice = m_slice_cnt[t];
                    o.rnp    = m_keeps[t];
                end
            end
            default: ;
        endcase
        o.run_task    = m_cur_valid ? m_cur : 4'd0;
        o.run_valid   = m_cur_valid;
        o.ready_total = m_ready_cnt;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Traffic shaping. idle_mode 0: sender idles 9 %, receiver 67 %.
    // idle_mode 1: the other way round. idle_mode 2: no idling at all.
    // ------------------------------------------------------------------
    int idle_mode;
    int hold_req;     // bumped by the stimulus to ask for a long receiver stall
    int hold_seen;
    int hold_left;

    // Receiver: checks each result transaction against the oldest expectation.
    always @(posedge aclk) begin
        sched_rsp_t e;
        int pct;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                $error("result transaction with no expectation pending");
                err_cnt++;
            end else begin
                e = pending_rsp.pop_front();
                if (m_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_status);
                    err_cnt++;
                end
                if (m_running_task !== e.run_task) begin
                    $error("running_task: expected %0d, got %0d", e.run_task, m_running_task);
                    err_cnt++;
                end
                if (m_running_valid !== e.run_valid) begin
                    $error("running_valid: expected %0d, got %0d", e.run_valid,
                           m_running_valid);
                    err_cnt++;
                end
                if (m_switched !== e.switched) begin
                    $error("switched: expected %0d, got %0d", e.switched, m_switched);
                    err_cnt++;
                end
                if (m_created_task !== e.created) begin
                    $error("created_task: expected %0d, got %0d", e.created, m_created_task);
                    err_cnt++;
                end
                if (m_read_priority !== e.rprio) begin
                    $error("read_priority: expected %0d, got %0d", e.rprio, m_read_priority);
                    err_cnt++;
                end
                if (m_read_slice_left !== e.rslice) begin
                    $error("read_slice_left: expected %0d, got %0d", e.rslice,
                           m_read_slice_left);
                    err_cnt++;
                end
                if (m_read_non_preemptive !== e.rnp) begin
                    $error("read_non_preemptive: expected %0d, got %0d", e.rnp,
                           m_read_non_preemptive);
                    err_cnt++;
                end
                if (m_ready_total !== e.ready_total) begin
                    $error("ready_total: expected %0d, got %0d", e.ready_total, m_ready_total);
                    err_cnt++;
                end
            end
        end
        // A new stall request starts a long hold-off counted here.
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = 300;
        end
        pct = (idle_mode == 0) ? 67 : (idle_mode == 1) ? 9 : 0;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= pct);
        end
    end

    // Offers one request transaction and waits for it to be accepted. The
    // caller is always positioned just after a rising edge.
    task automatic offer_request(sched_req_t r, logic known, sched_rsp_t known_rsp);
        sched_rsp_t p;
        int pct;
        pct = (idle_mode == 0) ? 9 : (idle_mode == 1) ? 67 : 0;
        while ($urandom_range(0, 99) < pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_action         <= r.action;
        s_task_id        <= r.tid;
        s_use_current    <= r.usecur;
        s_new_priority   <= r.prio;
        s_slice_value    <= r.slice;
        s_non_preemptive <= r.np;
        s_force_req      <= r.frc;
        do @(posedge aclk); while (!s_ready);
        p = schedule_outcome(r);
        pending_rsp.push_back(known ? known_rsp : p);
    endtask

    // Lets every expected result arrive, then waits on for the pipeline to settle.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_floor(logic [4:0] v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        m_floor    = v;
        @(posedge aclk);
    endtask

    function automatic sched_req_t mk_req(logic [3:0] a, logic [3:0] tid, logic uc,
                                          logic [4:0] pr, logic [15:0] sl, logic np,
                                          logic frc);
        sched_req_t r;
        r = '{action: a, tid: tid, usecur: uc, prio: pr, slice: sl, np: np, frc: frc};
        return r;
    endfunction

    function automatic sched_rsp_t mk_rsp(logic [1:0] st, logic [3:0] rt, logic rv,
                                          logic sw, logic [3:0] cr, logic [4:0] rp,
                                          logic [15:0] rs, logic rn, logic [4:0] tot);
        sched_rsp_t o;
        o = '{status: st, run_task: rt, run_valid: rv, switched: sw, created: cr,
              rprio: rp, rslice: rs, rnp: rn, ready_total: tot};
        return o;
    endfunction

    // Random request. Mostly well-formed traffic on a small set of levels so
    // that preemption, rotation and blocking keep happening; now and then a
    // full-range value or an unused action code.
    function automatic sched_req_t random_request();
        sched_req_t r;
        int w;
        r = mk_req(ACT_QUERY, 4'($urandom_range(0, 15)), ($urandom_range(0, 3) == 0),
                   5'($urandom_range(8, 12)), 16'($urandom_range(0, 4)),
                   1'($urandom_range(0, 1)), ($urandom_range(0, 4) == 0));
        if ($urandom_range(0, 9) == 0) r.prio  = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 7) == 0) r.slice = 16'($urandom_range(0, 65535));
        w = $urandom_range(0, 99);
        if      (w < 14) r.action = ACT_CREATE;
        else if (w < 20) r.action = ACT_SET_PRIO;
        else if (w < 24) r.action = ACT_RESTORE;
        else if (w < 28) r.action = ACT_SET_SLICE;
        else if (w < 33) r.action = ACT_MODE;
        else if (w < 43) r.action = ACT_WAKE;
        else if (w < 51) r.action = ACT_BLOCK;
        else if (w < 71) r.action = ACT_SCHEDULE;
        else if (w < 89) r.action = ACT_TICK;
        else if (w < 97) r.action = ACT_QUERY;
        else             r.action = 4'($urandom_range(10, 15));
        return r;
    endfunction

    dir_row_t dir_table[$];

    initial begin
        sched_req_t r;
        int n;
        int target;
        aresetn          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        s_valid          <= 1'b0;
        s_action         <= '0;
        s_task_id        <= '0;
        s_use_current    <= 1'b0;
        s_new_priority   <= '0;
        s_slice_value    <= '0;
        s_non_preemptive <= 1'b0;
        s_force_req      <= 1'b0;
        idle_mode = 0;
        hold_req  = 0;
        mirror_reset();

        // Empty table: every addressed action fails, nothing to run.
        dir_table.push_back('{mk_req(ACT_QUERY, 0, 0, 0, 0, 0, 0), 1'b1,
                              mk_rsp(STS_WRONG, 0, 0, 0, 0, 0, 0, 0, 0)});
        dir_table.push_back('{mk_req(ACT_BLOCK, 0, 0, 0, 0, 0, 0), 1'b1,
                              mk_rsp(STS_WRONG, 0, 0, 0, 0, 0, 0, 0, 0)});
        dir_table.push_back('{mk_req(ACT_TICK, 0, 0, 0, 0, 0, 0), 1'b1,
                              mk_rsp(STS_OK, 0, 0, 0, 0, 0, 0, 0, 0)});
        dir_table.push_back('{mk_req(ACT_SCHEDULE, 0, 0, 0, 0, 0, 1), 1'b1,
                              mk_rsp(STS_OK, 0, 0, 0, 0, 0, 0, 0, 0)});
        // Extreme priorities and slices.
        dir_table.push_back('{mk_req(ACT_CREATE, 15, 1, 0, 16'hFFFF, 1, 1), 1'b1,
                              mk_rsp(STS_OK, 0, 0, 0, 0, 0, 0, 0, 1)});
        dir_table.push_back('{mk_req(ACT_CREATE, 0, 0, 31, 0, 0, 0), 1'b1,
                              mk_rsp(STS_OK, 0, 0, 0, 1, 0, 0, 0, 2)});
        // Below the reset floor of 8.
        dir_table.push_back('{mk_req(ACT_SET_PRIO, 1, 0, 7, 0, 0, 0), 1'b1,
                              mk_rsp(STS_BAD_PRIO, 0, 0, 0, 0, 0, 0, 0, 2)});
        dir_table.push_back('{mk_req(ACT_SCHEDULE, 0, 0, 0, 0, 0, 0), 1'b1,
                              mk_rsp(STS_OK, 0, 1, 1, 0, 0, 0, 0, 1)});
        dir_table.push_back('{mk_req(ACT_QUERY, 9, 1, 0, 0, 0, 0), 1'b1,
                              mk_rsp(STS_OK, 0, 1, 0, 0, 0, 16'hFFFF, 0, 1)});
        // Non-preemptive runner against an arrival at its own level, then forced.
        dir_table.push_back('{mk_req(ACT_MODE, 0, 1, 0, 0, 1, 0), 1'b0, '0});
        dir_table.push_back('{mk_req(ACT_CREATE, 0, 0, 0, 2, 0, 0), 1'b0, '0});
        dir_table.push_back('{mk_req(ACT_SCHEDULE, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_table.push_back('{mk_req(ACT_SCHEDULE, 0, 0, 0, 0, 0, 1), 1'b0, '0});
        // Slice runs out, the same level rotates.
        dir_table.push_back('{mk_req(ACT_TICK, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_table.push_back('{mk_req(ACT_TICK, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_table.push_back('{mk_req(ACT_TICK, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_table.push_back('{mk_req(ACT_SCHEDULE, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        // Priority change and restore on a ready task, slice rewrite on the running one.
        dir_table.push_back('{mk_req(ACT_SET_PRIO, 1, 0, 8, 0, 0, 0), 1'b0, '0});
        dir_table.push_back('{mk_req(ACT_RESTORE, 1, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_table.push_back('{mk_req(ACT_SET_SLICE, 0, 1, 0, 16'hFFFF, 0, 0), 1'b0, '0});
        // Wake of a task that does not wait, then block the runner and wake a ready task.
        dir_table.push_back('{mk_req(ACT_WAKE, 1, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_table.push_back('{mk_req(ACT_BLOCK, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_table.push_back('{mk_req(ACT_WAKE, 2, 0, 0, 0, 0, 0), 1'b0, '0});
        // Free slot addressed, and an unused action code.
        dir_table.push_back('{mk_req(ACT_QUERY, 15, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_table.push_back('{mk_req(4'd15, 15, 1, 31, 16'hFFFF, 1, 1), 1'b0, '0});

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_table[i]) offer_request(dir_table[i].req, dir_table[i].known_rsp,
                                             dir_table[i].rsp);

        // Four random phases, each with its own floor write; idle modes 0, 1, then 2 twice.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_floor(5'd0);
                1: write_floor(5'd31);
                2: write_floor(5'($urandom_range(1, 30)));
                default: write_floor(FLOOR_RESET);
            endcase
            idle_mode = (ph < 2) ? ph : 2;
            target = 100;
            n = 0;
            while (n < target) begin
                r = random_request();
                offer_request(r, 1'b0, '0);
                if (r.action <= ACT_QUERY) n++;
                if (ph == 2 && n == 40) hold_req++;
                // Sender waits for the block to go quiet in mid phase.
                if (ph == 3 && n == 50) drain_results();
            end
        end

        drain_results();
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
